### src/dctd_pkg.sv
`default_nettype none
package dctd_pkg;

	localparam int STEP_W = 3;
	typedef logic [STEP_W-1:0] step_t;

	localparam logic [19:0] CYCLE_DAYS  = 20'd146097;
	localparam logic [12:0] CYCLE_YEARS = 13'd400;
	localparam logic [12:0] BASE_YEAR   = 13'd2000;
	localparam logic [8:0]  YEAR_DAYS   = 9'd365;
	localparam logic [8:0]  LEAP_DAYS   = 9'd366;
	localparam logic [6:0]  CENTURY_END = 7'd99;
	localparam logic [3:0]  LAST_MONTH  = 4'd11;
	localparam logic [3:0]  FEBRUARY    = 4'd1;

	typedef enum logic [2:0] {
		OP_NOP       = 3'd0,
		OP_LOAD      = 3'd1,
		OP_SUB_CYCLE = 3'd2,
		OP_SUB_YEAR  = 3'd3,
		OP_SUB_MONTH = 3'd4,
		OP_EMIT      = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		C_ALWAYS   = 3'd0,
		C_IN       = 3'd1,
		C_GE_CYCLE = 3'd2,
		C_GE_YEAR  = 3'd3,
		C_GE_MONTH = 3'd4,
		C_OUT_FREE = 3'd5
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		step_t tgt_true;
		step_t tgt_false;
	} uword_t;

	typedef struct packed {
		op_t  op;
		logic fire;
		logic idle;
	} ctrl_t;

	typedef struct packed {
		logic in_valid;
		logic ge_cycle;
		logic ge_year;
		logic ge_month;
		logic out_free;
	} flags_t;

	localparam step_t S_LOAD  = 3'd0;
	localparam step_t S_CYCLE = 3'd1;
	localparam step_t S_YEAR  = 3'd2;
	localparam step_t S_MONTH = 3'd3;
	localparam step_t S_EMIT  = 3'd4;

	function automatic uword_t urom(input step_t a);
		uword_t w;
		unique case (a)
			S_LOAD:  w = '{OP_LOAD,      C_IN,       S_CYCLE, S_LOAD};
			S_CYCLE: w = '{OP_SUB_CYCLE, C_GE_CYCLE, S_CYCLE, S_YEAR};
			S_YEAR:  w = '{OP_SUB_YEAR,  C_GE_YEAR,  S_YEAR,  S_MONTH};
			S_MONTH: w = '{OP_SUB_MONTH, C_GE_MONTH, S_MONTH, S_EMIT};
			S_EMIT:  w = '{OP_EMIT,      C_OUT_FREE, S_LOAD,  S_EMIT};
			default: w = '{OP_NOP,       C_ALWAYS,   S_LOAD,  S_LOAD};
		endcase
		return w;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] n;
		unique case (m)
			4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: n = 5'd31;
			4'd3, 4'd5, 4'd8, 4'd10:                   n = 5'd30;
			FEBRUARY:                                  n = leap ? 5'd29 : 5'd28;
			default:                                   n = 5'd31;
		endcase
		return n;
	endfunction

	// 8 == 1 mod 7: fold octal digits
	function automatic logic [2:0] mod7(input logic [19:0] d);
		logic [5:0] s;
		logic [3:0] s2;
		logic [3:0] r;
		s = 6'(d[2:0]) + 6'(d[5:3]) + 6'(d[8:6]) + 6'(d[11:9])
		  + 6'(d[14:12]) + 6'(d[17:15]) + 6'(d[19:18]);
		s2 = 4'(s[5:3]) + 4'(s[2:0]);
		r = (s2 >= 4'd7) ? s2 - 4'd7 : s2;
		return r[2:0];
	endfunction

endpackage
`default_nettype wire

### src/day_count_to_date.sv
// Steps: load, then subtract 400-year periods (up to 7), years past the period (up to 399)
//   and months (up to 11), then emit once the output register is free.
// A new item is taken only in the load step, which follows emit; the year loop dominates.
// A finished result waits in the output register while the next item is taken.
// Reset: arst_n asynchronous, active low; sequencer returns to load step, output invalid.
`default_nettype none
module day_count_to_date (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [19:0] day_count,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [12:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day_of_month,
	output logic [2:0]  weekday
);

	dctd_pkg::ctrl_t  ctrl;
	dctd_pkg::flags_t flags;

	logic        ge_cycle, ge_year, ge_month;
	logic [12:0] dp_year;
	logic [3:0]  dp_month;
	logic [4:0]  dp_dom;
	logic [2:0]  dp_wd;

	logic        out_valid_q;
	logic [12:0] year_q;
	logic [3:0]  month_q;
	logic [4:0]  dom_q;
	logic [2:0]  wd_q;
	logic        emit;

	assign flags = '{in_valid: in_valid, ge_cycle: ge_cycle, ge_year: ge_year,
		ge_month: ge_month, out_free: !out_valid_q || !out_stall};

	dctd_seq u_seq (
		.clk   (clk),
		.arst_n(arst_n),
		.flags (flags),
		.ctrl  (ctrl)
	);

	dctd_dp u_dp (
		.clk         (clk),
		.ctrl        (ctrl),
		.day_count   (day_count),
		.ge_cycle    (ge_cycle),
		.ge_year     (ge_year),
		.ge_month    (ge_month),
		.year        (dp_year),
		.month       (dp_month),
		.day_of_month(dp_dom),
		.weekday     (dp_wd)
	);

	assign in_stall = !ctrl.idle;
	assign emit     = ctrl.fire && (ctrl.op == dctd_pkg::OP_EMIT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			year_q  <= dp_year;
			month_q <= dp_month;
			dom_q   <= dp_dom;
			wd_q    <= dp_wd;
		end
	end

	assign out_valid    = out_valid_q;
	assign year         = year_q;
	assign month        = month_q;
	assign day_of_month = dom_q;
	assign weekday      = wd_q;

endmodule
`default_nettype wire

### src/dctd_seq.sv
`default_nettype none
module dctd_seq (
	input  wire              clk,
	input  wire              arst_n,
	input  dctd_pkg::flags_t flags,
	output dctd_pkg::ctrl_t  ctrl
);

	dctd_pkg::step_t  step_q;
	dctd_pkg::uword_t uw;
	logic             cond_ok;

	always_comb begin
		uw = dctd_pkg::urom(step_q);
		unique case (uw.cond)
			dctd_pkg::C_ALWAYS:   cond_ok = 1'b1;
			dctd_pkg::C_IN:       cond_ok = flags.in_valid;
			dctd_pkg::C_GE_CYCLE: cond_ok = flags.ge_cycle;
			dctd_pkg::C_GE_YEAR:  cond_ok = flags.ge_year;
			dctd_pkg::C_GE_MONTH: cond_ok = flags.ge_month;
			dctd_pkg::C_OUT_FREE: cond_ok = flags.out_free;
			default:              cond_ok = 1'b0;
		endcase
		ctrl.op   = uw.op;
		ctrl.fire = cond_ok;
		ctrl.idle = (step_q == dctd_pkg::S_LOAD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= dctd_pkg::S_LOAD;
		end else begin
			step_q <= cond_ok ? uw.tgt_true : uw.tgt_false;
		end
	end

endmodule
`default_nettype wire

### src/dctd_dp.sv
`default_nettype none
module dctd_dp (
	input  wire              clk,
	input  dctd_pkg::ctrl_t  ctrl,
	input  wire  [19:0]      day_count,
	output logic             ge_cycle,
	output logic             ge_year,
	output logic             ge_month,
	output logic [12:0]      year,
	output logic [3:0]       month,
	output logic [4:0]       day_of_month,
	output logic [2:0]       weekday
);

	logic [19:0] days_q;
	logic [12:0] year_q;
	logic [1:0]  ymod4_q;
	logic [6:0]  ymod100_q;
	logic [1:0]  cent4_q;
	logic [3:0]  mon_q;
	logic [2:0]  wd_q;

	logic        leap;
	logic [8:0]  ylen;
	logic [4:0]  mlen;

	always_comb begin
		leap     = (ymod4_q == 2'd0) && ((ymod100_q != 7'd0) || (cent4_q == 2'd0));
		ylen     = leap ? dctd_pkg::LEAP_DAYS : dctd_pkg::YEAR_DAYS;
		mlen     = dctd_pkg::month_len(mon_q, leap);
		ge_cycle = days_q >= dctd_pkg::CYCLE_DAYS;
		ge_year  = days_q >= 20'(ylen);
		ge_month = (mon_q != dctd_pkg::LAST_MONTH) && (days_q >= 20'(mlen));
	end

	always_ff @(posedge clk) begin
		if (ctrl.fire) begin
			unique case (ctrl.op)
				dctd_pkg::OP_LOAD: begin
					days_q    <= day_count;
					wd_q      <= dctd_pkg::mod7(day_count);
					year_q    <= dctd_pkg::BASE_YEAR;
					ymod4_q   <= 2'd0;
					ymod100_q <= 7'd0;
					cent4_q   <= 2'd0;
					mon_q     <= 4'd0;
				end
				dctd_pkg::OP_SUB_CYCLE: begin
					days_q <= days_q - dctd_pkg::CYCLE_DAYS;
					year_q <= year_q + dctd_pkg::CYCLE_YEARS;
				end
				dctd_pkg::OP_SUB_YEAR: begin
					days_q  <= days_q - 20'(ylen);
					year_q  <= year_q + 13'd1;
					ymod4_q <= ymod4_q + 2'd1;
					if (ymod100_q == dctd_pkg::CENTURY_END) begin
						ymod100_q <= 7'd0;
						cent4_q   <= cent4_q + 2'd1;
					end else begin
						ymod100_q <= ymod100_q + 7'd1;
					end
				end
				dctd_pkg::OP_SUB_MONTH: begin
					days_q <= days_q - 20'(mlen);
					mon_q  <= mon_q + 4'd1;
				end
				dctd_pkg::OP_NOP, dctd_pkg::OP_EMIT: begin
				end
				default: begin
				end
			endcase
		end
	end

	assign year         = year_q;
	assign month        = mon_q + 4'd1;
	assign day_of_month = days_q[4:0] + 5'd1;
	assign weekday      = wd_q;

endmodule
`default_nettype wire

### verif/dctd_checker.sv
`timescale 1ns / 1ps
module dctd_checker (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	input  wire        in_stall,
	input  wire [19:0] day_count,
	input  wire        out_valid,
	input  wire        out_stall,
	input  wire [12:0] year,
	input  wire [3:0]  month,
	input  wire [4:0]  day_of_month,
	input  wire [2:0]  weekday,
	output int         mismatches,
	output int         outstanding
);

	typedef struct {
		logic [19:0] count;
		logic [12:0] yr;
		logic [3:0]  mo;
		logic [4:0]  dom;
		logic [2:0]  wd;
	} date_t;

	date_t expected_dates[$];

	function automatic bit gregorian_leap(input int unsigned y);
		return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
	endfunction

	function automatic int unsigned days_in_month(input int unsigned m, input bit leap);
		case (m)
			2: return leap ? 29 : 28;
			4, 6, 9, 11: return 30;
			default: return 31;
		endcase
	endfunction

	function automatic date_t calendar_date_of(input logic [19:0] count);
		date_t d;
		int unsigned rest;
		int unsigned y;
		int unsigned m;
		rest = count;
		y = 2000;
		while (rest >= (gregorian_leap(y) ? 366 : 365)) begin
			rest -= gregorian_leap(y) ? 366 : 365;
			y++;
		end
		m = 1;
		while (m < 12 && rest >= days_in_month(m, gregorian_leap(y))) begin
			rest -= days_in_month(m, gregorian_leap(y));
			m++;
		end
		d.count = count;
		d.yr = y[12:0];
		d.mo = m[3:0];
		d.dom = 5'(rest + 1);
		d.wd = 3'(count % 7);
		return d;
	endfunction

	always @(posedge clk) begin
		date_t want;
		if (!arst_n) begin
			mismatches = 0;
			outstanding = 0;
			expected_dates.delete();
		end else begin
			if (in_valid && !in_stall)
				expected_dates.push_back(calendar_date_of(day_count));
			if (out_valid && !out_stall) begin
				if (expected_dates.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: unexpected result %0d-%0d-%0d weekday %0d",
							$time, year, month, day_of_month, weekday);
				end else begin
					want = expected_dates.pop_front();
					if (year !== want.yr || month !== want.mo ||
						day_of_month !== want.dom || weekday !== want.wd) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"%0t: count %0d expected %0d-%0d-%0d weekday %0d,",
								" got %0d-%0d-%0d weekday %0d"}, $time, want.count,
								want.yr, want.mo, want.dom, want.wd,
								year, month, day_of_month, weekday);
					end
				end
			end
			outstanding = expected_dates.size();
		end
	end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
module tb;

	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 500;
	localparam int RANDOM_ITEMS = 200;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [19:0] day_count;
	logic        out_valid;
	logic        out_stall;
	logic [12:0] year;
	logic [3:0]  month;
	logic [4:0]  day_of_month;
	logic [2:0]  weekday;

	int mismatches;
	int outstanding;
	int idle_cycles = 0;
	int burst_left = 0;

	// leap days, month ends, century and 400-year boundaries, bit patterns, top of range
	logic [19:0] corner_counts[$] = '{
		20'd0, 20'd1, 20'd6, 20'd7, 20'd30, 20'd31, 20'd58, 20'd59, 20'd60,
		20'd365, 20'd366, 20'd36524, 20'd36583, 20'd36584, 20'd73049,
		20'd146096, 20'd146097, 20'd146156, 20'hAAAAA, 20'h55555,
		20'h80000, 20'hFFFFE, 20'hFFFFF
	};

	day_count_to_date uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.day_count    (day_count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month),
		.weekday      (weekday)
	);

	dctd_checker date_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.day_count    (day_count),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month),
		.weekday      (weekday),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int mode;
		int len;
		out_stall = 1'b0;
		forever begin
			mode = $urandom_range(0, 2);
			len = $urandom_range(20, 400);
			repeat (len) begin
				@(negedge clk);
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 1) == 1);
					default: out_stall <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	task automatic send_count(input logic [19:0] count);
		int gap;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 7);
			case ($urandom_range(0, 3))
				0: gap = 0;
				1, 2: gap = $urandom_range(1, 6);
				default: gap = $urandom_range(1, 450);
			endcase
		end
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		day_count <= count;
		do @(posedge clk); while (in_stall);
	endtask

	initial begin
		int base;
		int count;
		int hundreds;
		arst_n = 1'b0;
		in_valid = 1'b0;
		day_count = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (corner_counts[i])
			send_count(corner_counts[i]);

		repeat (RANDOM_ITEMS) begin
			case ($urandom_range(0, 4))
				0: count = $urandom_range(0, 2000);
				1: count = 20'hFFFFF - $urandom_range(0, 2000);
				2: begin
					hundreds = $urandom_range(0, 3);
					base = $urandom_range(0, 6) * 146097;
					if (hundreds > 0)
						base += 36525 + (hundreds - 1) * 36524;
					count = base + $urandom_range(0, 70) - (base > 0 ? 3 : 0);
				end
				default: count = $urandom_range(0, 20'hFFFFF);
			endcase
			send_count(count[19:0]);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
